// ===== src/mvsm_pkg.sv =====
// Package for the multi-voice sample mixer.
// Holds action and status codes, shared widths and the front-to-back job type.
package mvsm_pkg;

   localparam int STEP_W = 36;
   localparam int POS_W  = 52;
   localparam int LEN_W  = 17;
   localparam logic [LEN_W-1:0] MAX_LEN = 17'd65536;

   // Configuration register indexes
   localparam logic CSR_MIN_STEP = 1'b0;
   localparam logic CSR_MAX_STEP = 1'b1;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_DEFINE = 2'd1,
      ACT_TRIG   = 2'd2,
      ACT_RENDER = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   // One classified job passed from front to back.
   typedef struct packed {
      action_type  action;
      logic [15:0] mem_address;
      logic [15:0] sample_value;
      logic [5:0]  sound_id;
      logic [15:0] sound_start;
      logic [16:0] sound_length;
      logic [35:0] step;
      logic [15:0] gain;
      logic        block_start;
      logic [1:0]  status;
   } job_type;

endpackage

// ===== src/mvsm_req_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// No dependencies.
interface mvsm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] mem_address;
   logic signed [15:0] sample_value;
   logic [5:0]  sound_id;
   logic [15:0] sound_start;
   logic [16:0] sound_length;
   logic [35:0] pitch_step;
   logic signed [15:0] gain;
   logic        block_start;
   modport source (output valid, action, mem_address, sample_value, sound_id, sound_start,
                   sound_length, pitch_step, gain, block_start, input ready);
   modport sink (input valid, action, mem_address, sample_value, sound_id, sound_start,
                 sound_length, pitch_step, gain, block_start, output ready);
endinterface

interface mvsm_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] out_sample;
   logic [1:0]  status;
   modport source (output valid, out_sample, status, input ready);
   modport sink (input valid, out_sample, status, output ready);
endinterface

// ===== src/mvsm_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module mvsm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== src/mvsm_front.sv =====
// Front end: accepts requests, validates triggers against the sound table,
// clamps pitch steps and pushes classified jobs. Depends on mvsm_pkg.
module mvsm_front #(
   parameter int SOUND_SLOTS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   mvsm_req_if.sink               req,
   input  logic [35:0]            min_step,
   input  logic [35:0]            max_step,
   output logic                   job_valid,
   input  logic                   job_ready,
   output mvsm_pkg::job_type      job
);
   import mvsm_pkg::*;

   localparam int SW = (SOUND_SLOTS > 1) ? $clog2(SOUND_SLOTS) : 1;

   logic [SOUND_SLOTS-1:0] defined_ff, defined_in;
   logic                   slot_ok;
   logic [35:0]            step_c;
   job_type                j;

   assign req.ready = job_ready;
   assign slot_ok = ({26'd0, req.sound_id} < 32'(SOUND_SLOTS)) &&
                    defined_ff[req.sound_id[SW-1:0]];

   always_comb begin
      step_c = req.pitch_step;
      if (step_c < min_step) step_c = min_step;
      if (step_c > max_step) step_c = max_step;
   end

   // ring occupancy is judged in the back end, in order with drains
   always_comb begin
      j = '0;
      j.action       = action_type'(req.action);
      j.mem_address  = req.mem_address;
      j.sample_value = req.sample_value;
      j.sound_id     = req.sound_id;
      j.sound_start  = req.sound_start;
      j.sound_length = (req.sound_length > MAX_LEN) ? MAX_LEN : req.sound_length;
      j.step         = step_c;
      j.gain         = req.gain;
      j.block_start  = req.block_start;
      j.status       = ST_OK;
      if (req.action == ACT_TRIG) begin
         if (!slot_ok) j.status = ST_INVALID;
      end
   end

   // Mirror of which slots are defined, for trigger validation.
   always_comb begin
      defined_in = defined_ff;
      if (req.valid && req.ready && req.action == ACT_DEFINE &&
          {26'd0, req.sound_id} < 32'(SOUND_SLOTS))
         defined_in[req.sound_id[SW-1:0]] = (req.sound_length != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) defined_ff <= '0;
      else defined_ff <= defined_in;
   end

   assign job_valid = req.valid;
   assign job = j;
endmodule

// ===== src/mvsm_back.sv =====
// Back end: sample store, sound tables, trigger ring and the voice walker
// with one shared interpolator. Depends on mvsm_pkg and mvsm_ram.
module mvsm_back #(
   parameter int VOICE_COUNT  = 16,
   parameter int RING_DEPTH   = 16,
   parameter int SAMPLE_WORDS = 65536,
   parameter int SOUND_SLOTS  = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  mvsm_pkg::job_type job,
   mvsm_rsp_if.source        rsp
);
   import mvsm_pkg::*;

   localparam int AW = $clog2(SAMPLE_WORDS);
   localparam int SW = (SOUND_SLOTS > 1) ? $clog2(SOUND_SLOTS) : 1;
   localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int RW = $clog2(RING_DEPTH);
   localparam int TW = 6 + 36 + 16;

   typedef enum logic [3:0] {
      S_IDLE, S_DRAIN, S_DRAIN_W, S_VFETCH, S_VLEN, S_RD0, S_RD1, S_MUL, S_GAIN, S_ACC,
      S_SAT, S_OUT
   } state_type;

   state_type state_ff;
   logic [RW:0] head_ff, tail_ff;
   logic [VOICE_COUNT-1:0] act_ff;
   logic [5:0]  vsnd_ff [VOICE_COUNT];
   logic [POS_W-1:0] vpos_ff [VOICE_COUNT];
   logic [35:0] vstep_ff [VOICE_COUNT];
   logic [15:0] vgain_ff [VOICE_COUNT];
   logic [SOUND_SLOTS-1:0] sval_ff;
   logic [VW-1:0] v_ff;
   logic [15:0] a_ff;
   logic signed [33:0] interp_ff;
   logic signed [49:0] prod_ff;
   logic        prod_valid_ff;
   logic signed [23:0] acc_ff;
   logic [16:0] len_ff;
   logic [15:0] start_ff;
   logic [15:0] i0_ff, i1_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_sample_ff;
   logic [1:0]  rsp_status_ff;

   // Sample store
   logic          s_we;
   logic [AW-1:0] s_waddr, s_raddr;
   logic [15:0]   s_rdata;
   // Sound tables
   logic          t_we;
   logic [SW-1:0] t_raddr;
   logic [32:0]   t_rdata;
   // Trigger ring
   logic          r_we;
   logic [TW-1:0] r_rdata;
   logic          ring_full;
   logic          trig_full;

   logic take;
   logic rsp_load;
   logic voice_last;
   logic [VW-1:0] free_v;
   logic          free_ok;
   logic [15:0]   addr_sel;
   logic [POS_W-1:0] npos;

   assign voice_last = (32'(v_ff) == 32'(VOICE_COUNT - 1));
   assign ring_full  = (head_ff[RW] != tail_ff[RW]) && (head_ff[RW-1:0] == tail_ff[RW-1:0]);
   assign take       = job_valid && job_ready;

   assign s_we    = take && job.action == ACT_WRITE;
   assign s_waddr = AW'(job.mem_address);
   assign addr_sel = start_ff + ((state_ff == S_RD0) ? i0_ff : i1_ff);
   assign s_raddr = AW'(addr_sel);

   mvsm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_samples (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(job.sample_value),
      .rd_addr(s_raddr), .rd_data(s_rdata));

   assign t_we = take && job.action == ACT_DEFINE &&
                 ({26'd0, job.sound_id} < 32'(SOUND_SLOTS));
   assign t_raddr = SW'(vsnd_ff[v_ff]);

   mvsm_ram #(.WIDTH(33), .DEPTH(SOUND_SLOTS)) u_sounds (
      .clock(clock), .wr_en(t_we), .wr_addr(SW'(job.sound_id)),
      .wr_data({job.sound_start, job.sound_length}),
      .rd_addr(t_raddr), .rd_data(t_rdata));

   assign trig_full = (job.action == ACT_TRIG) && (job.status == ST_OK) && ring_full;
   assign r_we = take && job.action == ACT_TRIG && job.status == ST_OK && !ring_full;
   assign rsp_load = (take && job.action != ACT_RENDER) || (state_ff == S_SAT);

   mvsm_ram #(.WIDTH(TW), .DEPTH(RING_DEPTH)) u_ring (
      .clock(clock), .wr_en(r_we), .wr_addr(head_ff[RW-1:0]),
      .wr_data({job.sound_id, job.step, job.gain}),
      .rd_addr(tail_ff[RW-1:0]), .rd_data(r_rdata));

   always_comb begin
      free_v  = '0;
      free_ok = 1'b0;
      for (int k = VOICE_COUNT - 1; k >= 0; k--) begin
         if (!act_ff[k]) begin
            free_v  = VW'(k);
            free_ok = 1'b1;
         end
      end
   end

   assign npos = vpos_ff[v_ff] + {16'd0, vstep_ff[v_ff]};
   assign job_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         act_ff        <= '0;
         sval_ff       <= '0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= (state_ff == S_GAIN);
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  if (t_we) sval_ff[SW'(job.sound_id)] <= 1'b1;
                  if (r_we) head_ff <= head_ff + 1'b1;
                  if (job.action == ACT_RENDER) begin
                     acc_ff <= '0;
                     v_ff   <= '0;
                     state_ff <= (job.block_start && head_ff != tail_ff) ? S_DRAIN : S_VFETCH;
                  end else begin
                     rsp_sample_ff <= '0;
                     rsp_status_ff <= trig_full ? ST_FULL : job.status;
                  end
               end
            end
            S_DRAIN: state_ff <= S_DRAIN_W;  // ring read latency
            S_DRAIN_W: begin
               if (free_ok) begin
                  act_ff[free_v]   <= 1'b1;
                  vsnd_ff[free_v]  <= r_rdata[TW-1 -: 6];
                  vpos_ff[free_v]  <= '0;
                  vstep_ff[free_v] <= r_rdata[51:16];
                  vgain_ff[free_v] <= r_rdata[15:0];
               end
               tail_ff  <= tail_ff + 1'b1;
               state_ff <= (tail_ff + 1'b1 != head_ff) ? S_DRAIN : S_VFETCH;
            end
            S_VFETCH: state_ff <= act_ff[v_ff] ? S_VLEN : S_ACC;
            S_VLEN: begin
               start_ff <= t_rdata[32:17];
               len_ff   <= sval_ff[t_raddr] ? t_rdata[16:0] : 17'd0;
               i0_ff    <= vpos_ff[v_ff][47:32];
               i1_ff    <= vpos_ff[v_ff][47:32] + 16'd1;
               if ({15'd0, vpos_ff[v_ff][51:32]} >= {18'd0, (sval_ff[t_raddr] ?
                   t_rdata[16:0] : 17'd0)}) begin
                  act_ff[v_ff] <= 1'b0;
                  state_ff <= S_ACC;
               end else begin
                  if ({1'b0, vpos_ff[v_ff][47:32]} + 17'd1 >= t_rdata[16:0])
                     i1_ff <= vpos_ff[v_ff][47:32];
                  state_ff <= S_RD0;
               end
            end
            S_RD0: state_ff <= S_RD1;
            S_RD1: begin
               a_ff <= s_rdata;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               interp_ff <= 34'(signed'(a_ff)) * 34'sd65536 +
                            (34'(signed'(s_rdata)) - 34'(signed'(a_ff))) *
                            $signed({18'd0, vpos_ff[v_ff][31:16]});
               state_ff <= S_GAIN;
            end
            S_GAIN: begin
               prod_ff  <= 50'(interp_ff) * 50'(signed'(vgain_ff[v_ff]));
               vpos_ff[v_ff] <= npos;
               if ({15'd0, npos[51:32]} >= {18'd0, len_ff}) act_ff[v_ff] <= 1'b0;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               // add the product when this voice went through the interpolator
               if (prod_valid_ff)
                  acc_ff <= acc_ff +
                            24'((prod_ff + (prod_ff[49] ? 50'sd268435455 : 50'sd0)) >>> 28);
               state_ff <= voice_last ? S_SAT : S_VFETCH;
               v_ff <= v_ff + 1'b1;
            end
            S_SAT: begin
               rsp_status_ff <= ST_OK;
               rsp_sample_ff <= (acc_ff > 24'sd32767) ? 16'h7FFF :
                                (acc_ff < -24'sd32768) ? 16'h8000 : acc_ff[15:0];
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_sample = rsp_sample_ff;
   assign rsp.status     = rsp_status_ff;
endmodule

// ===== src/mvsm_fifo.sv =====
// Two-entry job queue between front and back ends.
// Depends on mvsm_pkg.
module mvsm_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mvsm_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output mvsm_pkg::job_type out_job
);
   import mvsm_pkg::*;
   job_type q_ff [2];
   logic [1:0] cnt_ff;
   logic rd_ff, wr_ff;
   logic push, pop;
   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         if (push) begin
            q_ff[wr_ff] <= in_job;
            wr_ff <= ~wr_ff;
         end
         if (pop) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// ===== src/multi_voice_sample_mixer.sv =====
// Multi-voice sample mixer top level: front end, job queue, back end.
// A render drains the queued triggers when block_start is set, then walks every voice in
// turn; active voices pass through the shared interpolator unless they retire on lookup.
// One item is processed at a time in the back end; the front end queues up to two ahead.
// Synchronous active-high reset clears voices, ring pointers and slot valid bits.
// Depends on mvsm_pkg, the channel interfaces, mvsm_front, mvsm_fifo, mvsm_back.
module multi_voice_sample_mixer #(
   parameter int VOICE_COUNT  = 16,
   parameter int RING_DEPTH   = 16,
   parameter int SAMPLE_WORDS = 65536,
   parameter int SOUND_SLOTS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   mvsm_req_if.sink    req,
   mvsm_rsp_if.source  rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [35:0] csr_data
);
   import mvsm_pkg::*;

   logic [35:0] min_ff, max_ff;
   logic f_valid, f_ready, b_valid, b_ready;
   job_type f_job, b_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 36'd1073741824;
         max_ff <= 36'd17179869184;
      end else if (csr_write) begin
         if (csr_index == CSR_MIN_STEP) min_ff <= csr_data;
         else max_ff <= csr_data;
      end
   end

   mvsm_front #(.SOUND_SLOTS(SOUND_SLOTS)) u_front (
      .clock(clock), .reset(reset), .req(req), .min_step(min_ff), .max_step(max_ff),
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

   mvsm_fifo u_fifo (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job));

   mvsm_back #(.VOICE_COUNT(VOICE_COUNT), .RING_DEPTH(RING_DEPTH),
               .SAMPLE_WORDS(SAMPLE_WORDS), .SOUND_SLOTS(SOUND_SLOTS)) u_back (
      .clock(clock), .reset(reset), .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .rsp(rsp));

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.out_sample))
      else $error("response changed while stalled");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.status != 2'd3)
      else $error("bad status code");
endmodule

// ===== dv/tb.sv =====
// Testbench for multi_voice_sample_mixer: directed and random action streams with
// a self-contained predictor of voices, sound tables and the trigger ring.
// Depends on mvsm_pkg, mvsm_req_if, mvsm_rsp_if and the mixer RTL.
`timescale 1ns / 1ps

module tb;
   import mvsm_pkg::*;

   localparam int VOICES     = 16;
   localparam int RING_SLOTS = 16;
   localparam int REGION_LO  = 65530;
   localparam int REGION_SZ  = 12;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [35:0] STEP_ALL = 36'hF_FFFF_FFFF;

   typedef struct {
      action_type         act;
      logic [15:0]        addr;
      logic signed [15:0] value;
      logic [5:0]         id;
      logic [15:0]        start;
      logic [16:0]        len;
      logic [35:0]        pitch;
      logic signed [15:0] gain;
      logic               bstart;
   } mix_req_type;

   typedef struct {
      logic signed [15:0] frame;
      status_type         st;
   } mix_rsp_type;

   logic clock = 1'b0;
   logic reset;
   logic        csr_write;
   logic        csr_index;
   logic [35:0] csr_data;

   mvsm_req_if req_ch ();
   mvsm_rsp_if rsp_ch ();

   multi_voice_sample_mixer u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [35:0]        min_step_m, max_step_m;
   logic signed [15:0] sample_mem [0:65535];
   logic [15:0]        snd_start_m [64];
   logic [16:0]        snd_len_m [64];
   logic [5:0]         ring_snd [RING_SLOTS];
   logic [35:0]        ring_step [RING_SLOTS];
   logic signed [15:0] ring_gain [RING_SLOTS];
   int                 ring_wr, ring_rd;
   bit                 v_on [VOICES];
   logic [5:0]         v_snd [VOICES];
   logic [51:0]        v_pos [VOICES];
   logic [35:0]        v_step [VOICES];
   logic signed [15:0] v_gain [VOICES];

   mix_rsp_type frames_due[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  gaps_on = 1'b1;
   int  stall_left = 0;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic move_triggers();
      int slot;
      while (ring_wr != ring_rd) begin
         slot = ring_rd % RING_SLOTS;
         for (int v = 0; v < VOICES; v++) begin
            if (!v_on[v]) begin
               v_on[v]   = 1'b1;
               v_snd[v]  = ring_snd[slot];
               v_pos[v]  = '0;
               v_step[v] = ring_step[slot];
               v_gain[v] = ring_gain[slot];
               break;
            end
         end
         ring_rd = (ring_rd + 1) % (2 * RING_SLOTS);
      end
   endtask

   task automatic mix_frame(output logic signed [15:0] frame);
      longint acc, a, b, interp;
      int     len, i0, i1, frac;
      acc = 0;
      for (int v = 0; v < VOICES; v++) begin
         if (!v_on[v]) continue;
         len = snd_len_m[v_snd[v]];
         i0  = v_pos[v][51:32];
         if (i0 >= len) begin
            v_on[v] = 1'b0;
            continue;
         end
         i1     = (i0 + 1 < len) ? i0 + 1 : i0;
         frac   = v_pos[v][31:16];
         a      = sample_mem[(snd_start_m[v_snd[v]] + i0) & 16'hFFFF];
         b      = sample_mem[(snd_start_m[v_snd[v]] + i1) & 16'hFFFF];
         interp = a * 65536 + (b - a) * frac;
         acc   += (interp * longint'(v_gain[v])) / 268435456;
         v_pos[v] = v_pos[v] + 52'(v_step[v]);
         if (int'(v_pos[v][51:32]) >= len) v_on[v] = 1'b0;
      end
      if (acc > 32767) acc = 32767;
      else if (acc < -32768) acc = -32768;
      frame = 16'(acc);
   endtask

   task automatic predict_item(input mix_req_type it, output mix_rsp_type res);
      logic [35:0] stp;
      int          slot;
      res.frame = '0;
      res.st    = ST_OK;
      case (it.act)
         ACT_WRITE: sample_mem[it.addr] = it.value;
         ACT_DEFINE: begin
            snd_start_m[it.id] = it.start;
            snd_len_m[it.id]   = (it.len > MAX_LEN) ? MAX_LEN : it.len;
         end
         ACT_TRIG: begin
            if (snd_len_m[it.id] == 0) res.st = ST_INVALID;
            else if ((ring_wr - ring_rd + 2 * RING_SLOTS) % (2 * RING_SLOTS) >= RING_SLOTS)
               res.st = ST_FULL;
            else begin
               stp = it.pitch;
               if (stp < min_step_m) stp = min_step_m;
               if (stp > max_step_m) stp = max_step_m;
               slot = ring_wr % RING_SLOTS;
               ring_snd[slot]  = it.id;
               ring_step[slot] = stp;
               ring_gain[slot] = it.gain;
               ring_wr = (ring_wr + 1) % (2 * RING_SLOTS);
            end
         end
         default: begin
            if (it.bstart) move_triggers();
            mix_frame(res.frame);
         end
      endcase
   endtask

   task automatic send_item(input mix_req_type it);
      mix_rsp_type res;
      int          n;
      req_ch.valid        <= 1'b1;
      req_ch.action       <= it.act;
      req_ch.mem_address  <= it.addr;
      req_ch.sample_value <= it.value;
      req_ch.sound_id     <= it.id;
      req_ch.sound_start  <= it.start;
      req_ch.sound_length <= it.len;
      req_ch.pitch_step   <= it.pitch;
      req_ch.gain         <= it.gain;
      req_ch.block_start  <= it.bstart;
      do @(posedge clock); while (!req_ch.ready);
      predict_item(it, res);
      frames_due = {frames_due, res};
      n = gap_len();
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (frames_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_steps(input logic [35:0] lo, input logic [35:0] hi);
      wait_drained();
      repeat (20) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_MIN_STEP;
      csr_data  <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_STEP;
      csr_data  <= hi;
      @(posedge clock);
      csr_write <= 1'b0;
      min_step_m = lo;
      max_step_m = hi;
   endtask

   function automatic mix_req_type blank_item(action_type act);
      mix_req_type it;
      it.act    = act;
      it.addr   = '0;
      it.value  = '0;
      it.id     = '0;
      it.start  = '0;
      it.len    = '0;
      it.pitch  = '0;
      it.gain   = '0;
      it.bstart = 1'b0;
      return it;
   endfunction

   function automatic mix_req_type write_item(int addr, int value);
      mix_req_type it;
      it       = blank_item(ACT_WRITE);
      it.addr  = 16'(addr);
      it.value = 16'(value);
      return it;
   endfunction

   function automatic mix_req_type define_item(int id, int start, int len);
      mix_req_type it;
      it       = blank_item(ACT_DEFINE);
      it.id    = 6'(id);
      it.start = 16'(start);
      it.len   = 17'(len);
      return it;
   endfunction

   function automatic mix_req_type trig_item(int id, logic [35:0] pitch, int gain);
      mix_req_type it;
      it       = blank_item(ACT_TRIG);
      it.id    = 6'(id);
      it.pitch = pitch;
      it.gain  = 16'(gain);
      return it;
   endfunction

   function automatic mix_req_type render_item(bit bstart);
      mix_req_type it;
      it        = blank_item(ACT_RENDER);
      it.bstart = bstart;
      return it;
   endfunction

   // defined sounds always lie inside the written region, which wraps at the top
   function automatic mix_req_type rand_item();
      int r, o;
      r = $urandom_range(0, 99);
      if (r < 14) begin
         if ($urandom_range(0, 4) == 0) return write_item($urandom, $urandom);
         return write_item(REGION_LO + $urandom_range(0, REGION_SZ - 1),
                           ($urandom_range(0, 9) == 0) ? -32768 : $urandom);
      end
      if (r < 26) begin
         o = $urandom_range(0, REGION_SZ - 1);
         return define_item($urandom_range(0, 63), REGION_LO + o,
                            ($urandom_range(0, 19) == 0) ? 0 :
                            $urandom_range(1, REGION_SZ - o));
      end
      if (r < 58)
         return trig_item($urandom_range(0, 63), {4'($urandom), 32'($urandom)},
                          ($urandom_range(0, 9) == 0) ? 32767 : $urandom);
      return render_item($urandom_range(0, 3) == 0);
   endfunction

   task automatic test_directed();
      int vals [REGION_SZ] = '{32767, -32768, 1000, -1000, 0, 32767,
                               -32768, 12345, -1, 1, 32767, -32768};
      for (int i = 0; i < REGION_SZ; i++) send_item(write_item(REGION_LO + i, vals[i]));
      send_item(define_item(0, REGION_LO, REGION_SZ));     // wraps past the top address
      send_item(define_item(63, 16'hFFFF, 17'h1FFFF));     // overlong length saturates
      send_item(trig_item(5, 36'd0, 4096));                // never defined
      send_item(define_item(63, REGION_LO + 4, 2));        // shortened before any render
      send_item(trig_item(0, STEP_ALL, -32768));
      send_item(trig_item(63, 36'h0_4000_0000, 32767));
      send_item(trig_item(0, 36'h1_8000_0000, 4096));
      send_item(render_item(1'b0));
      send_item(render_item(1'b1));
      for (int i = 0; i < 4; i++) send_item(render_item(1'b0));
   endtask

   task automatic test_ring_full();
      for (int i = 0; i < RING_SLOTS + 3; i++)
         send_item(trig_item(0, {4'($urandom), 32'($urandom)}, $urandom));
      send_item(render_item(1'b1));
      for (int i = 0; i < 6; i++) send_item(render_item(1'b0));
   endtask

   task automatic test_random(input int count, input bit idle);
      gaps_on = idle;
      for (int i = 0; i < count; i++) begin
         send_item(rand_item());
         if (i % 150 == 149) wait_drained();
      end
      gaps_on = 1'b1;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frames_due.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_ch.out_sample, 0);
            end else begin
               mix_rsp_type want;
               want = frames_due.pop_front();
               if (rsp_ch.out_sample !== want.frame)
                  report_mismatch("out_sample", rsp_ch.out_sample, want.frame);
               if (rsp_ch.status !== want.st)
                  report_mismatch("status", rsp_ch.status, want.st);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall_left = gap_len();
            rsp_ch.ready <= (stall_left == 0);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_write)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset        <= 1'b1;
      csr_write    <= 1'b0;
      csr_index    <= CSR_MIN_STEP;
      csr_data     <= '0;
      req_ch.valid <= 1'b0;
      req_ch.action       <= ACT_WRITE;
      req_ch.mem_address  <= '0;
      req_ch.sample_value <= '0;
      req_ch.sound_id     <= '0;
      req_ch.sound_start  <= '0;
      req_ch.sound_length <= '0;
      req_ch.pitch_step   <= '0;
      req_ch.gain         <= '0;
      req_ch.block_start  <= 1'b0;
      min_step_m = 36'd1073741824;
      max_step_m = 36'd17179869184;
      ring_wr = 0;
      ring_rd = 0;
      for (int i = 0; i < 64; i++) begin
         snd_start_m[i] = '0;
         snd_len_m[i]   = '0;
      end
      for (int v = 0; v < VOICES; v++) begin
         v_on[v]   = 1'b0;
         v_snd[v]  = '0;
         v_pos[v]  = '0;
         v_step[v] = '0;
         v_gain[v] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_ring_full();
      test_random(300, 1'b1);
      set_steps(36'd0, STEP_ALL);
      test_random(250, 1'b0);
      set_steps(36'd0, 36'd0);                     // new triggers get step 0, so their voices never advance
      test_random(150, 1'b1);
      test_ring_full();
      set_steps(STEP_ALL, 36'h0_8000_0000);        // inverted clamps
      test_random(200, 1'b1);
      set_steps(36'h0_0800_0000, 36'h8_0000_0000);
      test_random(300, 1'b1);

      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/mvsm_pkg.sv
src/mvsm_req_if.sv
src/mvsm_ram.sv
src/mvsm_front.sv
src/mvsm_back.sv
src/mvsm_fifo.sv
src/multi_voice_sample_mixer.sv
dv/tb.sv
